// ===== sv/npfe_pkg.sv =====
// ----------------------------------------------------------------------------
// npfe_pkg
// Shared types, constants and tables of the NMEA position field extractor.
// ----------------------------------------------------------------------------
package npfe_pkg;

	// Default parameter values.
	localparam int FRACTION_DIGITS_DEF = 4;
	localparam int ID_CHARS_DEF        = 5;

	// Magnitude limit of a parsed number and the widths that hold it.
	localparam int          ACC_W      = 30;
	localparam int          POW_W      = 20;
	localparam int          FRAC_CNT_W = 3;
	localparam int          VAL_W      = 31;
	localparam logic [29:0] SAT_LIMIT  = 30'd999999999;

	// Field indexes; fields beyond LAST_TOKEN are ignored.
	localparam logic [2:0] TOK_ID     = 3'd0;
	localparam logic [2:0] TOK_LAT    = 3'd2;
	localparam logic [2:0] LAST_TOKEN = 3'd4;

	// Reset value of the expected sentence ID ("GPGGA").
	localparam logic [63:0] SID_RESET   = 64'h0000_0047_5047_4741;
	localparam logic [7:0]  DELIM_RESET = 8'h2C;

	// Configuration register indexes.
	localparam logic [0:0] CFG_SENTENCE_ID = 1'b0;
	localparam logic [0:0] CFG_FIELD_DELIM = 1'b1;

	// Character codes.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Output stream width: 66 bits of fields padded to whole bytes.
	localparam int TDATA_W = 72;

	// State of the number being parsed in the current field.
	typedef struct packed {
		logic                  neg;
		logic                  point;
		logic                  digit;
		logic                  started;
		logic                  stopped;
		logic [FRAC_CNT_W-1:0] frac;
		logic [ACC_W-1:0]      acc;
	} num_t;

	// One result item.
	typedef struct packed {
		logic                    id_matched;
		logic                    lon_updated;
		logic                    lat_updated;
		logic signed [VAL_W-1:0] lon_value;
		logic signed [VAL_W-1:0] lat_value;
		logic                    status;
	} res_t;

	// Powers of ten used to scale up a number with missing fraction digits.
	function automatic logic [POW_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
		logic [POW_W-1:0] r;
		case (k)
			3'd0:    r = 20'd1;
			3'd1:    r = 20'd10;
			3'd2:    r = 20'd100;
			3'd3:    r = 20'd1000;
			3'd4:    r = 20'd10000;
			3'd5:    r = 20'd100000;
			3'd6:    r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/npfe_num.sv =====
// ----------------------------------------------------------------------------
// npfe_num
// Decimal number unit: folds one character into the number state and scales
// the finished number to its fixed-point value.
// ----------------------------------------------------------------------------
module npfe_num #(
	parameter int FRACTION_DIGITS = npfe_pkg::FRACTION_DIGITS_DEF
) (
	input  npfe_pkg::num_t                         num_cur,
	input  logic [7:0]                             c,
	output npfe_pkg::num_t                         num_nxt,
	output logic signed [npfe_pkg::VAL_W-1:0]      fin_val
);

	localparam int ACC_W  = npfe_pkg::ACC_W;
	localparam int PROD_W = npfe_pkg::ACC_W + npfe_pkg::POW_W;
	localparam int FCW    = npfe_pkg::FRAC_CNT_W;

	logic             is_blank;
	logic             is_sign;
	logic             is_digit;
	logic [ACC_W+3:0] push_wide;
	logic [ACC_W-1:0] push_sat;

	assign is_blank = (c == npfe_pkg::CH_SPACE) || (c == npfe_pkg::CH_TAB) ||
		(c == npfe_pkg::CH_LF) || (c == npfe_pkg::CH_VT) || (c == npfe_pkg::CH_FF);
	assign is_sign  = (c == npfe_pkg::CH_PLUS) || (c == npfe_pkg::CH_MINUS);
	assign is_digit = (c >= npfe_pkg::CH_ZERO) && (c <= npfe_pkg::CH_NINE);

	// Multiply by ten and add the digit, saturating at the limit.
	always_comb begin
		push_wide = ((ACC_W+4)'(num_cur.acc) << 3) + ((ACC_W+4)'(num_cur.acc) << 1)
			+ (ACC_W+4)'(c - npfe_pkg::CH_ZERO);
		push_sat = (push_wide > (ACC_W+4)'(npfe_pkg::SAT_LIMIT)) ?
			npfe_pkg::SAT_LIMIT : push_wide[ACC_W-1:0];
	end

	// Number syntax: blanks, optional sign, digits with at most one point.
	always_comb begin
		num_nxt = num_cur;
		if (num_cur.stopped || (!num_cur.started && is_blank)) begin
			num_nxt = num_cur;
		end else if (!num_cur.started && is_sign) begin
			num_nxt.neg     = (c == npfe_pkg::CH_MINUS);
			num_nxt.started = 1'b1;
		end else if ((c == npfe_pkg::CH_POINT) && !num_cur.point) begin
			num_nxt.point   = 1'b1;
			num_nxt.started = 1'b1;
		end else if (is_digit) begin
			num_nxt.digit   = 1'b1;
			num_nxt.started = 1'b1;
			if (!num_cur.point) begin
				num_nxt.acc = push_sat;
			end else if (num_cur.frac < FCW'(FRACTION_DIGITS)) begin
				num_nxt.acc  = push_sat;
				num_nxt.frac = num_cur.frac + 1'b1;
			end
		end else begin
			num_nxt.stopped = 1'b1;
		end
	end

	// Pad missing fraction digits with one constant multiply, then saturate.
	logic [FCW-1:0]    pad;
	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  mag;

	always_comb begin
		pad  = FCW'(FRACTION_DIGITS) - num_cur.frac;
		prod = PROD_W'(num_cur.acc) * PROD_W'(npfe_pkg::pow10(pad));
		mag  = (prod > PROD_W'(npfe_pkg::SAT_LIMIT)) ? npfe_pkg::SAT_LIMIT : prod[ACC_W-1:0];
		fin_val = num_cur.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

// ===== sv/npfe_parser.sv =====
// ----------------------------------------------------------------------------
// npfe_parser
// Sentence framing, field splitting, ID check and held position values.
// Processes one byte per enabled cycle and flags a result on sentence close.
// ----------------------------------------------------------------------------
module npfe_parser #(
	parameter int FRACTION_DIGITS = npfe_pkg::FRACTION_DIGITS_DEF,
	parameter int ID_CHARS        = npfe_pkg::ID_CHARS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [8*ID_CHARS-1:0] cfg_data,
	input  logic                  en,
	input  logic [7:0]            c,
	output logic                  res_vld,
	output npfe_pkg::res_t        res
);

	localparam int SID_W = 8 * ID_CHARS;
	localparam int POS_W = $clog2(ID_CHARS + 1);
	localparam int IDX_W = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
	localparam int VAL_W = npfe_pkg::VAL_W;

	// Configuration registers.
	logic [SID_W-1:0] sid_q;
	logic [7:0]       delim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sid_q   <= SID_W'(npfe_pkg::SID_RESET);
			delim_q <= npfe_pkg::DELIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				npfe_pkg::CFG_SENTENCE_ID: sid_q   <= cfg_data;
				npfe_pkg::CFG_FIELD_DELIM: delim_q <= cfg_data[7:0];
				default:                   sid_q   <= sid_q;
			endcase
		end
	end

	// Parser state.
	logic                    in_sent_q, in_sent_d;
	logic                    in_tok_q, in_tok_d;
	logic [2:0]              tok_q, tok_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic                    eq_q, eq_d;
	logic                    rej_q, rej_d;
	logic                    idok_q, idok_d;
	logic [1:0]              marks_q, marks_d;
	logic signed [VAL_W-1:0] lat_q, lat_d;
	logic signed [VAL_W-1:0] lon_q, lon_d;
	npfe_pkg::num_t          num_q, num_d, num_chr;
	logic signed [VAL_W-1:0] fin_val;

	npfe_num #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_num (
		.num_cur(num_q),
		.c      (c),
		.num_nxt(num_chr),
		.fin_val(fin_val)
	);

	// Expected ID characters, first character in the highest byte.
	logic [7:0] id_bytes [ID_CHARS];

	always_comb begin
		for (int i = 0; i < ID_CHARS; i++) begin
			id_bytes[i] = sid_q[8*(ID_CHARS-1-i) +: 8];
		end
	end

	logic active;
	logic num_field;
	logic fin;

	assign active    = !rej_q && (tok_q <= npfe_pkg::LAST_TOKEN);
	assign num_field = (tok_q == npfe_pkg::TOK_LAT) || (tok_q == npfe_pkg::LAST_TOKEN);

	// Next-state logic for one byte, with the field finish applied last.
	always_comb begin
		in_sent_d = in_sent_q;
		in_tok_d  = in_tok_q;
		tok_d     = tok_q;
		pos_d     = pos_q;
		eq_d      = eq_q;
		rej_d     = rej_q;
		idok_d    = idok_q;
		marks_d   = marks_q;
		lat_d     = lat_q;
		lon_d     = lon_q;
		num_d     = num_q;
		res_vld   = 1'b0;
		fin       = 1'b0;

		if (en) begin
			if (c == npfe_pkg::CH_DOLLAR) begin
				in_sent_d = 1'b1;
				in_tok_d  = 1'b0;
				tok_d     = npfe_pkg::TOK_ID;
				pos_d     = '0;
				eq_d      = 1'b1;
				rej_d     = 1'b0;
				idok_d    = 1'b0;
				marks_d   = '0;
				num_d     = '0;
			end else if (in_sent_q) begin
				if (c == npfe_pkg::CH_CR) begin
					fin       = in_tok_q && active;
					in_sent_d = 1'b0;
					in_tok_d  = 1'b0;
					res_vld   = 1'b1;
				end else if (active) begin
					if (c == delim_q) begin
						fin = in_tok_q;
					end else begin
						in_tok_d = 1'b1;
						if (tok_q == npfe_pkg::TOK_ID) begin
							if (pos_q < POS_W'(ID_CHARS)) begin
								if (id_bytes[pos_q[IDX_W-1:0]] != c) begin
									eq_d = 1'b0;
								end
								pos_d = pos_q + 1'b1;
							end else begin
								eq_d = 1'b0;
							end
						end else if (num_field) begin
							num_d = num_chr;
						end
					end
				end
			end
		end

		// Close the current field.
		if (fin) begin
			if (tok_q == npfe_pkg::TOK_ID) begin
				if (eq_q && (pos_q == POS_W'(ID_CHARS))) begin
					idok_d = 1'b1;
				end else begin
					rej_d = 1'b1;
				end
			end else if (num_field && num_q.digit) begin
				if (tok_q == npfe_pkg::TOK_LAT) begin
					lat_d      = fin_val;
					marks_d[0] = 1'b1;
				end else begin
					lon_d      = fin_val;
					marks_d[1] = 1'b1;
				end
			end
			num_d    = '0;
			in_tok_d = 1'b0;
			if (tok_q <= npfe_pkg::LAST_TOKEN) begin
				tok_d = tok_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			in_tok_q  <= 1'b0;
			tok_q     <= '0;
			pos_q     <= '0;
			eq_q      <= 1'b1;
			rej_q     <= 1'b0;
			idok_q    <= 1'b0;
			marks_q   <= '0;
			lat_q     <= '0;
			lon_q     <= '0;
			num_q     <= '0;
		end else begin
			in_sent_q <= in_sent_d;
			in_tok_q  <= in_tok_d;
			tok_q     <= tok_d;
			pos_q     <= pos_d;
			eq_q      <= eq_d;
			rej_q     <= rej_d;
			idok_q    <= idok_d;
			marks_q   <= marks_d;
			lat_q     <= lat_d;
			lon_q     <= lon_d;
			num_q     <= num_d;
		end
	end

	// Result of a closing byte, taken from the updated state.
	always_comb begin
		res.status      = rej_d;
		res.lat_value   = lat_d;
		res.lon_value   = lon_d;
		res.lat_updated = marks_d[0];
		res.lon_updated = marks_d[1];
		res.id_matched  = idok_d;
	end

endmodule

// ===== sv/nmea_position_field_extractor_top.sv =====
// ----------------------------------------------------------------------------
// nmea_position_field_extractor_top
// NMEA sentence parser that extracts the two position fields of a sentence.
// ----------------------------------------------------------------------------
// The block takes one received character per clock while s_tready is high,
// and gives one result item for each carriage return that closes a sentence
// opened by '$'. A byte is registered on entry and then processed by a single
// pass of parser logic, whose longest path is the constant multiply that
// scales a finished field; a closing byte's result is held in the output
// register. The output register lets a new byte enter while a result waits,
// so the sustained rate is one byte per cycle whenever the sink keeps up.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it while the block is idle, which the block itself does not enforce.
module nmea_position_field_extractor_top #(
	parameter int FRACTION_DIGITS = npfe_pkg::FRACTION_DIGITS_DEF,
	parameter int ID_CHARS        = npfe_pkg::ID_CHARS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [8*ID_CHARS-1:0]          cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] status, [31:1] lat_value, [62:32] lon_value, [63] lat_updated,
	// [64] lon_updated, [65] id_matched, [71:66] zero
	output logic [npfe_pkg::TDATA_W-1:0]   m_tdata
);

	localparam int RES_W = $bits(npfe_pkg::res_t);

	logic           byte_vld_s1;
	logic [7:0]     byte_s1;
	logic           out_free;
	logic           proc;
	logic           res_vld;
	npfe_pkg::res_t res;
	npfe_pkg::res_t res_q;
	logic           out_vld_q;

	assign out_free = !out_vld_q || m_tready;
	assign proc     = byte_vld_s1 && out_free;
	assign s_tready = !byte_vld_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	npfe_parser #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.ID_CHARS       (ID_CHARS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.en       (proc),
		.c        (byte_s1),
		.res_vld  (res_vld),
		.res      (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= proc && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && proc && res_vld) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(npfe_pkg::TDATA_W - RES_W)'(0), res_q};

endmodule

// ===== sv/npfe_chk.sv =====
// ----------------------------------------------------------------------------
// npfe_chk
// Port-level checks of the NMEA position field extractor, bound to its top.
// ----------------------------------------------------------------------------
module npfe_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [7:0]                   s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [npfe_pkg::TDATA_W-1:0] m_tdata
);

	// A stalled result item holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// A new result follows an accepted carriage return.
	a_cr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) &&
			($past(s_tdata, 2) == npfe_pkg::CH_CR))
		else $error("result item without a closing byte");

	// A rejected sentence reports no match and no updates.
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[63] && !m_tdata[64] && !m_tdata[65])
		else $error("rejected sentence shows updates");

	// Position updates need a matched sentence ID; padding stays zero.
	a_upd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[65] |-> !m_tdata[63] && !m_tdata[64] &&
			(m_tdata[71:66] == 6'd0))
		else $error("update without ID match");

endmodule

bind nmea_position_field_extractor_top npfe_chk u_npfe_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
